/* src/fpa_pkg.sv */
package fpa_pkg;

  // pool geometry
  localparam int NumBlocks    = 256;
  localparam int BlockIdxW    = $clog2(NumBlocks);
  localparam int LinkW        = BlockIdxW + 1;
  localparam int FreeW        = BlockIdxW + 1;
  localparam int PointerBytes = 8;

  // field widths
  localparam int BlockSizeW = 17;
  localparam int AlignW     = 13;
  localparam int ReqIdxW    = 12;
  localparam int StatusW    = 3;
  localparam int GrantIdxW  = 8;
  localparam int OffsetW    = 24;
  localparam int BytesW     = 25;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = BlockSizeW;

  // register reset values
  localparam logic [BlockSizeW-1:0] BlockSizeReset = BlockSizeW'(64);
  localparam logic [AlignW-1:0]     PoolAlignReset = AlignW'(16);

  // result codes
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_SIZE      = 3'd2,
    ST_ALIGN     = 3'd3,
    ST_NOT_OWNED = 3'd4,
    ST_NULL      = 3'd5
  } status_t;

  // commands
  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_SIZE = 1'b0,
    CFG_POOL_ALIGN = 1'b1
  } cfg_idx_t;

  // controller states
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_UPDATE = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic commit;
  } dp_ctrl_t;

endpackage

/* src/fpa_ctrl.sv */
module fpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output fpa_pkg::dp_ctrl_t  dp_ctrl
);
  import fpa_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_full;
  logic   out_full_next;
  logic   can_commit;

  // result register free or being drained this cycle
  assign can_commit = !out_full || out_ready;

  // state register and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (can_commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = 1'b0;
    dp_ctrl.load_in = 1'b0;
    dp_ctrl.commit  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready        = 1'b1;
        dp_ctrl.load_in = in_valid;
      end
      S_UPDATE: begin
        dp_ctrl.commit = can_commit;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // result held until the downstream transaction completes
  always_comb begin
    out_full_next = out_full;
    if (dp_ctrl.commit) out_full_next = 1'b1;
    else if (out_ready) out_full_next = 1'b0;
  end

  assign out_valid = out_full;

endmodule

/* src/fpa_datapath.sv */
module fpa_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  fpa_pkg::dp_ctrl_t                dp_ctrl,
  input  logic                             cfg_we,
  input  logic [fpa_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [fpa_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                             in_cmd,
  input  logic                             in_is_null,
  input  logic [fpa_pkg::BlockSizeW-1:0]   in_req_size,
  input  logic [fpa_pkg::AlignW-1:0]       in_req_align,
  input  logic [fpa_pkg::ReqIdxW-1:0]      in_block_index,
  output logic [fpa_pkg::StatusW-1:0]      out_status,
  output logic [fpa_pkg::GrantIdxW-1:0]    out_granted_index,
  output logic [fpa_pkg::OffsetW-1:0]      out_granted_offset,
  output logic [fpa_pkg::FreeW-1:0]        out_blocks_free,
  output logic [fpa_pkg::BytesW-1:0]       out_bytes_in_use
);
  import fpa_pkg::*;

  // configuration
  logic [BlockSizeW-1:0] block_size;
  logic [AlignW-1:0]     pool_align;

  // latched request
  logic                  req_cmd;
  logic                  req_is_null;
  logic [BlockSizeW-1:0] req_size;
  logic [AlignW-1:0]     req_align;
  logic [ReqIdxW-1:0]    req_idx;

  // free list state
  logic [LinkW-1:0]      list_head;
  logic [FreeW-1:0]      free_total;
  logic [LinkW-1:0]      link_mem [NumBlocks];
  logic [NumBlocks-1:0]  link_valid;
  logic [LinkW-1:0]      rd_link;
  logic                  rd_valid;
  logic [BlockIdxW-1:0]  rd_addr;

  // working values
  logic [BlockSizeW-1:0]           bsize;
  logic [LinkW-1:0]                head_link;
  logic                            size_bad;
  logic                            align_bad;
  logic                            exhausted;
  logic                            owned;
  logic                            do_pop;
  logic                            do_push;
  status_t                         status;
  logic [FreeW-1:0]                free_next;
  logic [FreeW-1:0]                used_cnt;
  logic [BlockIdxW+BlockSizeW-1:0] offset_prod;
  logic [FreeW+BlockSizeW-1:0]     bytes_prod;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BlockSizeReset;
      pool_align <= PoolAlignReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BLOCK_SIZE: block_size <= cfg_data;
        CFG_POOL_ALIGN: pool_align <= cfg_data[AlignW-1:0];
        default:        block_size <= block_size;
      endcase
    end
  end

  // request capture on an accepted transaction
  always_ff @(posedge clk) begin
    if (dp_ctrl.load_in) begin
      req_cmd     <= in_cmd;
      req_is_null <= in_is_null;
      req_size    <= in_req_size;
      req_align   <= in_req_align;
      req_idx     <= in_block_index;
    end
  end

  // link memory: head's next link read every cycle
  always_ff @(posedge clk) begin
    rd_link <= link_mem[list_head[BlockIdxW-1:0]];
    rd_addr <= list_head[BlockIdxW-1:0];
    if (do_push) link_mem[req_idx[BlockIdxW-1:0]] <= list_head;
  end

  // written flags, an unwritten entry links to the following block
  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= link_valid[list_head[BlockIdxW-1:0]];
      if (do_push) link_valid[req_idx[BlockIdxW-1:0]] <= 1'b1;
    end
  end

  assign head_link = rd_valid ? rd_link : (LinkW'(rd_addr) + LinkW'(1));

  // block size in effect is at least one pointer
  assign bsize = (block_size < BlockSizeW'(PointerBytes)) ? BlockSizeW'(PointerBytes)
                                                           : block_size;

  // request checks
  assign size_bad  = req_size > bsize;
  assign align_bad = req_align > pool_align;
  assign exhausted = list_head >= LinkW'(NumBlocks);
  assign owned     = req_idx < ReqIdxW'(NumBlocks);

  always_comb begin
    do_pop  = 1'b0;
    do_push = 1'b0;
    status  = ST_OK;
    if (cmd_t'(req_cmd) == CMD_ALLOC) begin
      if (size_bad)       status = ST_SIZE;
      else if (align_bad) status = ST_ALIGN;
      else if (exhausted) status = ST_EXHAUSTED;
      else                do_pop = dp_ctrl.commit;
    end else begin
      if (req_is_null) status = ST_NULL;
      else if (!owned) status = ST_NOT_OWNED;
      else             do_push = dp_ctrl.commit;
    end
  end

  // free count, saturating both ways
  always_comb begin
    free_next = free_total;
    if (do_pop && free_total != '0) free_next = free_total - FreeW'(1);
    else if (do_push && free_total < FreeW'(NumBlocks)) free_next = free_total + FreeW'(1);
  end

  // offset of the popped block and bytes in use
  assign used_cnt    = FreeW'(NumBlocks) - free_next;
  assign offset_prod = list_head[BlockIdxW-1:0] * bsize;
  assign bytes_prod  = used_cnt * bsize;

  // list update
  always_ff @(posedge clk) begin
    if (rst) begin
      list_head  <= '0;
      free_total <= FreeW'(NumBlocks);
    end else begin
      free_total <= free_next;
      if (do_pop) list_head <= head_link;
      else if (do_push) list_head <= LinkW'(req_idx[BlockIdxW-1:0]);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (dp_ctrl.commit) begin
      out_status         <= status;
      out_granted_index  <= do_pop ? GrantIdxW'(list_head[BlockIdxW-1:0]) : '0;
      out_granted_offset <= do_pop ? offset_prod[OffsetW-1:0] : '0;
      out_blocks_free    <= free_next;
      out_bytes_in_use   <= bytes_prod[BytesW-1:0];
    end
  end

endmodule

/* src/fixed_block_pool_allocator.sv */
// Fixed-size block pool of 256 blocks with a singly linked free list in an on-chip
// link memory. An allocate (tuser cmd 0) pops the head block and returns its index
// and byte offset, or a status of exhausted, size too big or alignment too big; a
// release (tuser cmd 1) pushes block_index back on the list, with null handles and
// indices outside the pool reported and ignored. Double releases are not checked.
// Every result carries the free block count and the bytes in use. The accept edge
// registers the head's next link out of the link memory, and the update state then
// commits the list update and loads the result register. The next transaction is
// taken while a result still waits downstream; a result that is not taken holds
// the commit of the following one. The link memory needs no clearing pass after
// reset: per-entry written flags give the initial chain at once. Configuration must
// be written only while the block is idle; the block itself does not enforce this.
module fixed_block_pool_allocator (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_we,
  input  logic [fpa_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [fpa_pkg::CfgDataW-1:0]       cfg_data,
  // request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [47:0]                        s_tdata,  // request_size, request_alignment, block_index
  input  logic [1:0]                         s_tuser,  // cmd, handle_is_null
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [71:0]                        m_tdata,  // granted_index, granted_offset, blocks_free, bytes_in_use
  output logic [fpa_pkg::StatusW-1:0]        m_tuser   // status
);
  import fpa_pkg::*;

  dp_ctrl_t                dp_ctrl;
  logic [GrantIdxW-1:0]    granted_index;
  logic [OffsetW-1:0]      granted_offset;
  logic [FreeW-1:0]        blocks_free;
  logic [BytesW-1:0]       bytes_in_use;

  fpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dp_ctrl   (dp_ctrl)
  );

  fpa_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .dp_ctrl            (dp_ctrl),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_cmd             (s_tuser[0]),
    .in_is_null         (s_tuser[1]),
    .in_req_size        (s_tdata[16:0]),
    .in_req_align       (s_tdata[29:17]),
    .in_block_index     (s_tdata[41:30]),
    .out_status         (m_tuser),
    .out_granted_index  (granted_index),
    .out_granted_offset (granted_offset),
    .out_blocks_free    (blocks_free),
    .out_bytes_in_use   (bytes_in_use)
  );

  // result packing, zero filled to whole bytes
  assign m_tdata = {6'b0, bytes_in_use, blocks_free, granted_offset, granted_index};

endmodule

/* test/tb_fixed_block_pool_allocator.sv */
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;
  import fpa_pkg::*;

  // one request as it travels on the request stream
  typedef struct packed {
    cmd_t                  cmd;
    logic [BlockSizeW-1:0] size;
    logic [AlignW-1:0]     align;
    logic [ReqIdxW-1:0]    idx;
    logic                  nul;
  } pool_req_t;

  // one reply as it travels on the result stream
  typedef struct packed {
    status_t              status;
    logic [GrantIdxW-1:0] gidx;
    logic [OffsetW-1:0]   goff;
    logic [FreeW-1:0]     free;
    logic [BytesW-1:0]    bytes;
  } pool_reply_t;

  // one line of the directed script
  typedef struct {
    pool_req_t   req;
    bit          typed;
    pool_reply_t reply;
  } script_line_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [47:0]         s_tdata;  // request_size, request_alignment, block_index
  logic [1:0]          s_tuser;  // cmd, handle_is_null
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [71:0]         m_tdata;  // granted_index, granted_offset, blocks_free, bytes_in_use
  logic [StatusW-1:0]  m_tuser;  // status

  // free list mirror
  logic [LinkW-1:0]      link_mem [NumBlocks];
  logic [LinkW-1:0]      list_head;
  logic [FreeW-1:0]      free_count;
  logic [BlockSizeW-1:0] cfg_block_size;
  logic [AlignW-1:0]     cfg_pool_align;

  pool_reply_t  pool_replies_due [$];
  int           held_blocks [$];
  script_line_t script_lines [$];
  int           mismatch_count = 0;
  bit           no_gaps = 1'b0;
  int           rx_wait = 0;
  pool_reply_t  rx_want;

  fixed_block_pool_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // block size in effect, never below a pointer
  function automatic int unsigned pool_unit();
    return (cfg_block_size < PointerBytes) ? PointerBytes : cfg_block_size;
  endfunction

  function automatic void init_free_list();
    for (int i = 0; i < NumBlocks; i++) link_mem[i] = LinkW'(i + 1);
    list_head      = '0;
    free_count     = FreeW'(NumBlocks);
    cfg_block_size = BlockSizeReset;
    cfg_pool_align = PoolAlignReset;
  endfunction

  // pop or push on the mirrored list, returns the reply the block owes
  function automatic pool_reply_t free_list_step(pool_req_t r);
    pool_reply_t      res;
    longint unsigned  unit;
    int               blk;
    unit = pool_unit();
    res  = '0;
    res.status = ST_OK;
    if (r.cmd == CMD_ALLOC) begin
      if (r.size > unit) begin
        res.status = ST_SIZE;
      end else if (r.align > cfg_pool_align) begin
        res.status = ST_ALIGN;
      end else if (list_head >= NumBlocks) begin
        res.status = ST_EXHAUSTED;
      end else begin
        blk = list_head;
        list_head = link_mem[blk];
        if (free_count > 0) free_count--;
        res.gidx = GrantIdxW'(blk);
        res.goff = OffsetW'(longint'(blk) * unit);
      end
    end else begin
      if (r.nul) begin
        res.status = ST_NULL;
      end else if (r.idx >= NumBlocks) begin
        res.status = ST_NOT_OWNED;
      end else begin
        link_mem[r.idx] = list_head;
        list_head = LinkW'(r.idx);
        if (free_count < NumBlocks) free_count++;
      end
    end
    res.free  = free_count;
    res.bytes = BytesW'(longint'(NumBlocks - free_count) * unit);
    return res;
  endfunction

  function automatic void check_field(string what, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic add_line(cmd_t c, int size, int align, int idx, bit nul, bit typed,
                          status_t st, int gi, int go, int fr, int by);
    script_line_t l;
    l.req.cmd     = c;
    l.req.size    = BlockSizeW'(size);
    l.req.align   = AlignW'(align);
    l.req.idx     = ReqIdxW'(idx);
    l.req.nul     = nul;
    l.typed       = typed;
    l.reply.status = st;
    l.reply.gidx  = GrantIdxW'(gi);
    l.reply.goff  = OffsetW'(go);
    l.reply.free  = FreeW'(fr);
    l.reply.bytes = BytesW'(by);
    script_lines.push_back(l);
  endtask

  // one request transaction, then book the reply it owes
  task automatic send_req(pool_req_t r, bit typed, pool_reply_t typed_reply);
    int          gap;
    pool_reply_t res;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, r.idx, r.align, r.size};
    s_tuser  <= {r.nul, r.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = free_list_step(r);
    pool_replies_due.push_back(typed ? typed_reply : res);
    // keep track of the blocks handed out
    if (res.status == ST_OK && r.cmd == CMD_ALLOC) begin
      held_blocks.push_back(int'(res.gidx));
    end else if (res.status == ST_OK) begin
      for (int i = 0; i < held_blocks.size(); i++) begin
        if (held_blocks[i] == int'(r.idx)) begin
          held_blocks.delete(i);
          break;
        end
      end
    end
    if ($urandom_range(0, 29) == 0) no_gaps = ~no_gaps;
  endtask

  // hold off the sender until every reply is back
  task automatic drain_pool(int settle);
    s_tvalid <= 1'b0;
    while (pool_replies_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_pool_config(int unsigned bsize, int unsigned align);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLOCK_SIZE;
    cfg_data  <= CfgDataW'(bsize);
    @(posedge clk);
    cfg_index <= CFG_POOL_ALIGN;
    cfg_data  <= CfgDataW'(align);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_block_size = BlockSizeW'(bsize);
    cfg_pool_align = AlignW'(align);
  endtask

  // mostly well formed allocates and releases, with some noise
  task automatic random_req(int alloc_pct, bit chaos, output pool_req_t r);
    int unsigned unit;
    int          roll;
    unit    = pool_unit();
    r.cmd   = CMD_ALLOC;
    r.size  = BlockSizeW'($urandom_range(0, 131071));
    r.align = AlignW'($urandom_range(0, 8191));
    r.idx   = ReqIdxW'($urandom_range(0, 4095));
    r.nul   = 1'($urandom_range(0, 1));
    roll    = $urandom_range(0, 99);
    if (roll < 15) begin
      case ($urandom_range(0, 4))
        0: begin
          if (unit < 131071) r.size = BlockSizeW'($urandom_range(unit + 1, 131071));
        end
        1: begin
          r.size = BlockSizeW'($urandom_range(0, unit));
          if (cfg_pool_align < 8191)
            r.align = AlignW'($urandom_range(cfg_pool_align + 1, 8191));
        end
        2: begin
          r.cmd = CMD_RELEASE;
          r.nul = 1'b1;
        end
        3: begin
          r.cmd = CMD_RELEASE;
          r.nul = 1'b0;
          if (!chaos) r.idx = ReqIdxW'($urandom_range(NumBlocks, 4095));
        end
        default: ;
      endcase
    end else if (roll < 15 + alloc_pct * 85 / 100 || held_blocks.size() == 0) begin
      r.size  = BlockSizeW'($urandom_range(0, unit));
      r.align = AlignW'($urandom_range(0, cfg_pool_align));
    end else begin
      r.cmd = CMD_RELEASE;
      r.nul = 1'b0;
      r.idx = ReqIdxW'(held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
      // any block at all, so double releases happen
      if (chaos && $urandom_range(0, 3) == 0) r.idx = ReqIdxW'($urandom_range(0, NumBlocks - 1));
    end
  endtask

  task automatic run_phase(int count, int alloc_pct, bit chaos);
    pool_req_t r;
    for (int i = 0; i < count; i++) begin
      random_req(alloc_pct, chaos, r);
      send_req(r, 1'b0, '0);
    end
  endtask

  // allocate until the pool runs dry, then knock on it a few more times
  task automatic fill_pool();
    pool_req_t r;
    int        n;
    n = 0;
    while (free_count > 0 && n < 400) begin
      random_req(100, 1'b0, r);
      send_req(r, 1'b0, '0);
      n++;
    end
    run_phase(8, 100, 1'b0);
  endtask

  // result side: random stalls between transactions
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (m_tvalid && m_tready) begin
      rx_wait  <= no_gaps ? 0 : $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait  <= rx_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each reply with the oldest one due
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pool_replies_due.size() == 0) begin
        $display("%0t: reply with none due, expected nothing actual status %0d",
                 $time, m_tuser);
        mismatch_count++;
      end else begin
        rx_want = pool_replies_due.pop_front();
        check_field("status", rx_want.status, m_tuser);
        check_field("granted_index", rx_want.gidx, m_tdata[7:0]);
        check_field("granted_offset", rx_want.goff, m_tdata[31:8]);
        check_field("blocks_free", rx_want.free, m_tdata[40:32]);
        check_field("bytes_in_use", rx_want.bytes, m_tdata[65:41]);
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_BLOCK_SIZE;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    init_free_list();

    // directed script at reset settings, typed replies read straight off the list
    add_line(CMD_ALLOC, 0, 1, 0, 0, 1, ST_OK, 0, 0, 255, 64);
    add_line(CMD_ALLOC, 64, 16, 0, 0, 1, ST_OK, 1, 64, 254, 128);
    add_line(CMD_ALLOC, 65, 1, 0, 0, 1, ST_SIZE, 0, 0, 254, 128);
    add_line(CMD_ALLOC, 64, 17, 0, 0, 1, ST_ALIGN, 0, 0, 254, 128);
    add_line(CMD_ALLOC, 131071, 8191, 0, 0, 1, ST_SIZE, 0, 0, 254, 128);
    add_line(CMD_ALLOC, 0, 8191, 0, 0, 1, ST_ALIGN, 0, 0, 254, 128);
    add_line(CMD_ALLOC, 0, 0, 0, 1, 1, ST_OK, 2, 128, 253, 192);
    add_line(CMD_RELEASE, 0, 0, 0, 1, 1, ST_NULL, 0, 0, 253, 192);
    add_line(CMD_RELEASE, 0, 0, 4095, 0, 1, ST_NOT_OWNED, 0, 0, 253, 192);
    add_line(CMD_RELEASE, 0, 0, 256, 0, 1, ST_NOT_OWNED, 0, 0, 253, 192);
    add_line(CMD_RELEASE, 0, 0, 1, 0, 1, ST_OK, 0, 0, 254, 128);
    add_line(CMD_ALLOC, 64, 16, 0, 0, 0, ST_OK, 0, 0, 0, 0);
    add_line(CMD_RELEASE, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0);
    add_line(CMD_RELEASE, 0, 0, 2, 0, 0, ST_OK, 0, 0, 0, 0);
    add_line(CMD_ALLOC, 8, 2, 4095, 1, 0, ST_OK, 0, 0, 0, 0);
    add_line(CMD_RELEASE, 131071, 8191, 1, 0, 0, ST_OK, 0, 0, 0, 0);
    add_line(CMD_RELEASE, 0, 0, 4095, 1, 0, ST_OK, 0, 0, 0, 0);
    add_line(CMD_ALLOC, 64, 16, 0, 0, 0, ST_OK, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script_lines[i]) send_req(script_lines[i].req, script_lines[i].typed,
                                       script_lines[i].reply);

    // block size 8 and alignment 1
    drain_pool(4);
    set_pool_config(8, 1);
    run_phase(50, 60, 1'b0);

    // block size 65536 and alignment 4096, run the pool dry
    drain_pool(4);
    set_pool_config(65536, 4096);
    fill_pool();

    // mostly releases
    drain_pool(4);
    set_pool_config(100, 8);
    run_phase(50, 25, 1'b0);

    // block size below a pointer, widest alignment field
    drain_pool(4);
    set_pool_config(0, 8191);
    run_phase(40, 50, 1'b0);

    // widest block size field, offsets wrap, zero alignment
    drain_pool(4);
    set_pool_config(131071, 0);
    run_phase(40, 70, 1'b0);

    // random settings, double releases allowed from here on
    drain_pool(4);
    set_pool_config($urandom_range(8, 65536), 1 << $urandom_range(0, 12));
    run_phase(50, 50, 1'b1);

    drain_pool(10);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
